// ===== hw/rtl/hufd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the Huffman decoder.
`timescale 1ns / 1ps
package hufd_pkg;

    localparam int NODE_COUNT = 256;
    localparam int COUNT_BITS = 16;

    localparam logic [2:0] KIND_SYMBOL     = 3'd0;
    localparam logic [2:0] KIND_MSG_DONE   = 3'd1;
    localparam logic [2:0] KIND_TREE_READY = 3'd2;
    localparam logic [2:0] KIND_TREE_ERROR = 3'd3;
    localparam logic [2:0] KIND_NO_TREE    = 3'd4;

    localparam logic CFG_REVERSE_BITS = 1'b0;
    localparam logic CFG_OUTPUT_LIMIT = 1'b1;

    typedef struct packed {
        logic accept;
        logic tree_start;
        logic leaf_write;
        logic link;
        logic alloc_new;
        logic pop_issue;
        logic pop_node;
        logic pop_load;
        logic tree_end;
        logic no_tree;
        logic msg_start;
        logic byte_load;
        logic lookup;
        logic step;
        logic msg_end;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic first;
        logic last;
        logic phase_active;
        logic await_leaf;
        logic side;
        logic depth_zero;
        logic node_full;
        logic tree_valid;
        logic msg_open;
        logic bits_zero;
        logic bits_one;
        logic emit_need;
        logic emit_ok;
        logic pend_valid;
        logic can_push;
    } t_stat;

endpackage

// ===== hw/rtl/hufd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== hw/rtl/hufd_datapath.sv =====
// Datapath: item and configuration registers, tree builder state, node and stack memories, walk and result queue.
`timescale 1ns / 1ps
module hufd_datapath #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT,
    parameter int COUNT_BITS = hufd_pkg::COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hufd_pkg::t_cmd   i_cmd,
    output hufd_pkg::t_stat  o_stat,
    input  logic             i_mode,
    input  logic [7:0]       i_data,
    input  logic             i_first,
    input  logic             i_last,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_symbol,
    output logic [15:0]      o_symbol_count,
    output logic             o_end_of_run
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = (IW > 8) ? IW : 8;
    localparam int EW = 2 + 2 * CW;
    localparam int FW = IW + 1;
    localparam int WW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_ACTIVE   = 2'd1;
    localparam logic [1:0] PH_COMPLETE = 2'd2;
    localparam logic [1:0] PH_FAILED   = 2'd3;

    logic r_mode, r_first, r_last;
    logic [7:0] r_data;
    logic r_rev;
    logic [15:0] r_limit;
    logic r_tree_valid;
    logic [1:0] r_phase;
    logic [IW-1:0] r_cur_idx;
    logic [1:0] r_cur_mask;
    logic [CW-1:0] r_cur_c0, r_cur_c1;
    logic r_side, r_await;
    logic [1:0] r_desc;
    logic [FW-1:0] r_next_free, r_depth;
    logic [IW-1:0] r_walk;
    logic [3:0] r_pad;
    logic r_open;
    logic [COUNT_BITS-1:0] r_sw;
    logic [7:0] r_byte;
    logic [3:0] r_bits;
    logic r_pvalid;
    logic [2:0] r_pkind;
    logic [7:0] r_psym;
    logic [15:0] r_pcnt;
    logic r_ovalid, r_oeor;
    logic [2:0] r_okind;
    logic [7:0] r_osym;
    logic [15:0] r_ocnt;

    logic node_we;
    logic [IW-1:0] node_wa, node_ra;
    logic [EW-1:0] node_wd, node_rd;
    logic stk_we;
    logic [IW-1:0] stk_wa, stk_ra, stk_rd;

    logic [1:0] rd_mask;
    logic [CW-1:0] rd_c0, rd_c1, rd_child;
    logic bit_now, leaf_now, can_count;
    logic [IW-1:0] n_walk;
    logic [WW-1:0] swx;
    logic [7:0] rev_data;
    logic [CW-1:0] new_child;
    logic [CW-1:0] upd_c0, upd_c1;
    logic node_full, can_push;
    logic emit_v;
    logic [2:0] emit_kind;
    logic [7:0] emit_sym;
    logic [15:0] emit_cnt;

    hufd_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk(i_clk), .i_wr_en(node_we), .i_wr_addr(node_wa), .i_wr_data(node_wd),
        .i_rd_addr(node_ra), .o_rd_data(node_rd)
    );

    hufd_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_stack_ram (
        .i_clk(i_clk), .i_wr_en(stk_we), .i_wr_addr(stk_wa), .i_wr_data(r_cur_idx),
        .i_rd_addr(stk_ra), .o_rd_data(stk_rd)
    );

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev_data[7-i] = r_data[i];
        end
    end

    assign rd_mask   = node_rd[EW-1 -: 2];
    assign rd_c1     = node_rd[2*CW-1 -: CW];
    assign rd_c0     = node_rd[CW-1:0];
    assign bit_now   = r_byte[7];
    assign leaf_now  = bit_now ? rd_mask[1] : rd_mask[0];
    assign rd_child  = bit_now ? rd_c1 : rd_c0;
    assign swx       = WW'(r_sw);
    assign can_count = (swx < WW'(r_limit)) && (r_sw != {COUNT_BITS{1'b1}});
    assign node_full = r_next_free >= FW'(NODE_COUNT);
    assign can_push  = !r_ovalid || !i_stall;

    always_comb begin
        n_walk = r_walk;
        if (i_cmd.step) begin
            if (leaf_now || ({1'b0, rd_child} >= (CW + 1)'(NODE_COUNT))) begin
                n_walk = '0;
            end else begin
                n_walk = rd_child[IW-1:0];
            end
        end
    end

    always_comb begin
        new_child = i_cmd.link ? CW'(r_next_free[IW-1:0]) : CW'(r_data);
        upd_c0 = r_side ? r_cur_c0 : new_child;
        upd_c1 = r_side ? new_child : r_cur_c1;
        node_we = 1'b0;
        node_wa = r_cur_idx;
        node_wd = {r_cur_mask, upd_c1, upd_c0};
        if (i_cmd.tree_start) begin
            node_we = 1'b1;
            node_wa = '0;
            node_wd = {r_data[1:0], {2 * CW{1'b0}}};
        end else if (i_cmd.leaf_write || (i_cmd.link && !node_full)) begin
            node_we = 1'b1;
        end else if (i_cmd.alloc_new) begin
            node_we = 1'b1;
            node_wa = r_next_free[IW-1:0];
            node_wd = {r_data[1:0], {2 * CW{1'b0}}};
        end
        stk_we = i_cmd.link && !node_full && !r_side;
        stk_wa = r_depth[IW-1:0];
        stk_ra = IW'(r_depth - FW'(1));
        if (i_cmd.pop_node) begin
            node_ra = stk_rd;
        end else begin
            node_ra = n_walk;
        end
    end

    always_comb begin
        emit_v = 1'b0;
        emit_kind = hufd_pkg::KIND_SYMBOL;
        emit_sym = '0;
        emit_cnt = '0;
        if (i_cmd.tree_end) begin
            emit_v = 1'b1;
            emit_kind = (r_phase == PH_COMPLETE) ? hufd_pkg::KIND_TREE_READY
                                                 : hufd_pkg::KIND_TREE_ERROR;
        end else if (i_cmd.no_tree) begin
            emit_v = 1'b1;
            emit_kind = hufd_pkg::KIND_NO_TREE;
        end else if (i_cmd.msg_start && r_last) begin
            emit_v = 1'b1;
            emit_kind = hufd_pkg::KIND_MSG_DONE;
        end else if (i_cmd.step && leaf_now && can_count) begin
            emit_v = 1'b1;
            emit_sym = rd_child[7:0];
        end else if (i_cmd.msg_end) begin
            emit_v = 1'b1;
            emit_kind = hufd_pkg::KIND_MSG_DONE;
            emit_cnt = swx[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_data <= i_data;
            r_first <= i_first;
            r_last <= i_last;
        end
        if (i_cmd.pop_node) begin
            r_cur_idx <= stk_rd;
        end
        if (i_cmd.pop_load) begin
            r_cur_mask <= rd_mask;
            r_cur_c0 <= rd_c0;
            r_cur_c1 <= rd_c1;
        end
        if (i_cmd.tree_start) begin
            r_cur_idx <= '0;
            r_cur_mask <= r_data[1:0];
            r_cur_c0 <= '0;
            r_cur_c1 <= '0;
        end
        if (i_cmd.leaf_write || (i_cmd.link && !node_full)) begin
            r_cur_c0 <= upd_c0;
            r_cur_c1 <= upd_c1;
        end
        if (i_cmd.alloc_new) begin
            r_cur_idx <= r_next_free[IW-1:0];
            r_cur_mask <= r_data[1:0];
            r_cur_c0 <= '0;
            r_cur_c1 <= '0;
        end
        if (i_cmd.byte_load) begin
            r_byte <= r_rev ? rev_data : r_data;
            r_bits <= r_last ? 4'd8 - r_pad : 4'd8;
        end
        if (i_cmd.step) begin
            r_byte <= {r_byte[6:0], 1'b0};
            r_bits <= r_bits - 4'd1;
        end
        if (i_cmd.msg_start) begin
            r_pad <= (r_data > 8'd8) ? 4'd8 : r_data[3:0];
        end
        if (emit_v) begin
            r_pkind <= emit_kind;
            r_psym <= emit_sym;
            r_pcnt <= emit_cnt;
        end
        if ((emit_v && r_pvalid) || i_cmd.finish) begin
            r_okind <= r_pkind;
            r_osym <= r_psym;
            r_ocnt <= r_pcnt;
            r_oeor <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= 1'b0;
            r_limit <= 16'hffff;
            r_tree_valid <= 1'b0;
            r_phase <= PH_IDLE;
            r_side <= 1'b0;
            r_await <= 1'b0;
            r_desc <= '0;
            r_next_free <= '0;
            r_depth <= '0;
            r_walk <= '0;
            r_open <= 1'b0;
            r_sw <= '0;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hufd_pkg::CFG_REVERSE_BITS: r_rev <= i_cfg_data[0];
                    hufd_pkg::CFG_OUTPUT_LIMIT: r_limit <= i_cfg_data;
                    default: r_rev <= r_rev;
                endcase
            end
            if (i_cmd.tree_start) begin
                r_tree_valid <= 1'b0;
                r_phase <= PH_ACTIVE;
                r_next_free <= FW'(1);
                r_depth <= '0;
                r_side <= 1'b0;
                r_desc <= r_data[1:0];
                r_await <= r_data[0];
            end
            if (i_cmd.leaf_write) begin
                if (!r_side) begin
                    r_side <= 1'b1;
                    r_await <= r_desc[1];
                end else if (r_depth == '0) begin
                    r_phase <= PH_COMPLETE;
                end
            end
            if (i_cmd.link) begin
                if (node_full) begin
                    r_phase <= PH_FAILED;
                end else if (!r_side) begin
                    r_depth <= r_depth + FW'(1);
                end
            end
            if (i_cmd.alloc_new) begin
                r_next_free <= r_next_free + FW'(1);
                r_side <= 1'b0;
                r_desc <= r_data[1:0];
                r_await <= r_data[0];
            end
            if (i_cmd.pop_issue) begin
                r_depth <= r_depth - FW'(1);
            end
            if (i_cmd.pop_load) begin
                r_desc <= rd_mask;
                r_side <= 1'b1;
                r_await <= rd_mask[1];
            end
            if (i_cmd.tree_end) begin
                if (r_phase == PH_COMPLETE) begin
                    r_tree_valid <= 1'b1;
                end
                r_phase <= PH_IDLE;
            end
            if (i_cmd.no_tree) begin
                r_open <= 1'b0;
            end
            if (i_cmd.msg_start) begin
                r_walk <= '0;
                r_sw <= '0;
                r_open <= !r_last;
            end
            if (i_cmd.step) begin
                r_walk <= n_walk;
                if (leaf_now && can_count) begin
                    r_sw <= r_sw + COUNT_BITS'(1);
                end
            end
            if (i_cmd.msg_end) begin
                r_open <= 1'b0;
            end
            if (emit_v) begin
                r_pvalid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pvalid <= 1'b0;
            end
            if ((emit_v && r_pvalid) || i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.mode = r_mode;
        o_stat.first = r_first;
        o_stat.last = r_last;
        o_stat.phase_active = r_phase == PH_ACTIVE;
        o_stat.await_leaf = r_await;
        o_stat.side = r_side;
        o_stat.depth_zero = r_depth == '0;
        o_stat.node_full = node_full;
        o_stat.tree_valid = r_tree_valid;
        o_stat.msg_open = r_open;
        o_stat.bits_zero = r_bits == 4'd0;
        o_stat.bits_one = r_bits == 4'd1;
        o_stat.emit_need = leaf_now && can_count;
        o_stat.emit_ok = !r_pvalid || can_push;
        o_stat.pend_valid = r_pvalid;
        o_stat.can_push = can_push;
    end

    assign o_valid = r_ovalid;
    assign o_kind = r_okind;
    assign o_symbol = r_osym;
    assign o_symbol_count = r_ocnt;
    assign o_end_of_run = r_oeor;

endmodule

// ===== hw/rtl/hufd_ctrl.sv =====
// Controller state machine that sequences tree loading and message decoding.
`timescale 1ns / 1ps
module hufd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hufd_pkg::t_stat i_stat,
    output hufd_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_ALLOC, S_POP1, S_POP2, S_POP3,
        S_TEND, S_LOOKUP, S_STEP, S_MEND, S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.mode) begin
                    if (i_stat.first) begin
                        o_cmd.tree_start = 1'b1;
                        n_state = S_TEND;
                    end else if (!i_stat.phase_active) begin
                        n_state = S_TEND;
                    end else if (i_stat.await_leaf) begin
                        o_cmd.leaf_write = 1'b1;
                        n_state = (i_stat.side && !i_stat.depth_zero) ? S_POP1 : S_TEND;
                    end else begin
                        o_cmd.link = 1'b1;
                        n_state = i_stat.node_full ? S_TEND : S_ALLOC;
                    end
                end else if (!i_stat.tree_valid) begin
                    o_cmd.no_tree = 1'b1;
                    n_state = S_FINISH;
                end else if (i_stat.first) begin
                    o_cmd.msg_start = 1'b1;
                    n_state = i_stat.last ? S_FINISH : S_IDLE;
                end else if (i_stat.msg_open) begin
                    o_cmd.byte_load = 1'b1;
                    n_state = S_LOOKUP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_new = 1'b1;
                n_state = S_TEND;
            end
            S_POP1: begin
                o_cmd.pop_issue = 1'b1;
                n_state = S_POP2;
            end
            S_POP2: begin
                o_cmd.pop_node = 1'b1;
                n_state = S_POP3;
            end
            S_POP3: begin
                o_cmd.pop_load = 1'b1;
                n_state = S_TEND;
            end
            S_TEND: begin
                if (i_stat.last) begin
                    o_cmd.tree_end = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = i_stat.bits_zero ? S_MEND : S_STEP;
            end
            S_STEP: begin
                if (!i_stat.emit_need || i_stat.emit_ok) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.bits_one) begin
                        n_state = S_MEND;
                    end
                end
            end
            S_MEND: begin
                if (!i_stat.last) begin
                    n_state = S_FINISH;
                end else if (i_stat.emit_ok) begin
                    o_cmd.msg_end = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.can_push) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !i_stat.pend_valid)
        else $error("pending result left when idle");
    a_step_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !i_stat.bits_zero)
        else $error("walk step with no bits left");
    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.alloc_new |-> !i_stat.node_full)
        else $error("node allocated in a full table");
    a_finish_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.can_push && i_stat.pend_valid)
        else $error("final beat pushed while output blocked");
`endif

endmodule

// ===== hw/rtl/huffman_tree_load_and_decode_top.sv =====
// Top level of the Huffman tree loader and decoder.
// A tree byte is accepted, dispatched and closed; one that opens a subtree also allocates a node,
// and one that closes a subtree pops the stack. A coded byte is loaded, looked up and walked bit by
// bit (up to 8 bits), one node-table read per bit. A last tree or pad beat or a no-tree beat also finishes.
// One item at a time; output stalls hold the walk in place and no results are lost.
// Synchronous active-low reset clears control state; node table and stack are undefined.
`timescale 1ns / 1ps
module huffman_tree_load_and_decode_top #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT,
    parameter int COUNT_BITS = hufd_pkg::COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data,
    input  logic        i_first,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_symbol,
    output logic [15:0] o_symbol_count,
    output logic        o_end_of_run,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    hufd_pkg::t_cmd  cmd;
    hufd_pkg::t_stat stat;

    hufd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_stat(stat), .o_cmd(cmd)
    );

    hufd_datapath #(.NODE_COUNT(NODE_COUNT), .COUNT_BITS(COUNT_BITS)) u_datapath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_mode(i_mode), .i_data(i_data), .i_first(i_first), .i_last(i_last),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_stall(i_stall), .o_valid(o_valid), .o_kind(o_kind), .o_symbol(o_symbol),
        .o_symbol_count(o_symbol_count), .o_end_of_run(o_end_of_run)
    );

endmodule
